// File: src/snbc_pkg.sv
package snbc_pkg;

   localparam int CODE_W    = 16;
   localparam int CHAR_BITS = 16;
   localparam int WORD_CAP  = 12;
   localparam int LEN_W     = 4;
   localparam int LETTER_W  = 5;

   localparam int DEF_MAX_COMMENT_DEPTH = 255;

   // code units are cut to CHAR_BITS before any compare
   localparam logic [CODE_W-1:0] CHAR_MASK = CODE_W'((64'd1 << CHAR_BITS) - 64'd1);

   localparam logic [CODE_W-1:0] CH_TAB   = 16'h0009;
   localparam logic [CODE_W-1:0] CH_LF    = 16'h000A;
   localparam logic [CODE_W-1:0] CH_CR    = 16'h000D;
   localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;
   localparam logic [CODE_W-1:0] CH_STAR  = 16'h002A;
   localparam logic [CODE_W-1:0] CH_DASH  = 16'h002D;
   localparam logic [CODE_W-1:0] CH_SLASH = 16'h002F;

   localparam logic [1:0] CLASS_ORDINARY    = 2'd0;
   localparam logic [1:0] CLASS_TXN_CONTROL = 2'd1;
   localparam logic [1:0] CLASS_NO_TXN      = 2'd2;

   typedef logic [WORD_CAP-1:0][LETTER_W-1:0] word_type;

   typedef enum logic [2:0] {
      CX_FIRST,
      CX_PREP,
      CX_CLUS,
      CX_CREATE,
      CX_UNIQUE,
      CX_INDEX,
      CX_DROP
   } ctx_type;

   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_SLASH,
      HELD_STAR,
      HELD_DASH
   } held_type;

   typedef struct packed {
      logic             done;
      logic [1:0]       cls;
      ctx_type          ctx;
      logic             in_word;
      logic             in_line;
      held_type         held;
      logic [LEN_W-1:0] wlen;
   } parse_type;

   localparam parse_type PARSE_RESET = '{
      done:    1'b0,
      cls:     CLASS_ORDINARY,
      ctx:     CX_FIRST,
      in_word: 1'b0,
      in_line: 1'b0,
      held:    HELD_NONE,
      wlen:    '0
   };

   typedef struct packed {
      logic is_abort;
      logic is_begin;
      logic is_start;
      logic is_commit;
      logic is_end;
      logic is_rollback;
      logic is_prepare;
      logic is_transaction;
      logic is_vacuum;
      logic is_cluster;
      logic is_create;
      logic is_database;
      logic is_tablespace;
      logic is_unique;
      logic is_index;
      logic is_concurrently;
      logic is_drop;
      logic is_reindex;
      logic is_system;
   } hits_type;

endpackage

// File: src/snbc_match.sv
module snbc_match import snbc_pkg::*; (
   input  word_type         letters,
   input  logic [LEN_W-1:0] wlen,
   output hits_type         hits
);

   // text is right-justified: its first character sits in byte n-1
   function automatic logic word_is(input word_type w, input logic [LEN_W-1:0] len,
                                    input logic [8*WORD_CAP-1:0] text, input int n);
      logic       ok;
      int         pos;
      logic [7:0] ch;
      ok = (len == LEN_W'(n));
      for (int i = 0; i < WORD_CAP; i++) begin
         if (i < n) begin
            pos = n - 1 - i;
            ch  = text[8*pos +: 8];
            ok  = ok & (w[i] == LETTER_W'(ch - 8'd97));
         end
      end
      return ok;
   endfunction

   assign hits.is_abort        = word_is(letters, wlen, "abort", 5);
   assign hits.is_begin        = word_is(letters, wlen, "begin", 5);
   assign hits.is_start        = word_is(letters, wlen, "start", 5);
   assign hits.is_commit       = word_is(letters, wlen, "commit", 6);
   assign hits.is_end          = word_is(letters, wlen, "end", 3);
   assign hits.is_rollback     = word_is(letters, wlen, "rollback", 8);
   assign hits.is_prepare      = word_is(letters, wlen, "prepare", 7);
   assign hits.is_transaction  = word_is(letters, wlen, "transaction", 11);
   assign hits.is_vacuum       = word_is(letters, wlen, "vacuum", 6);
   assign hits.is_cluster      = word_is(letters, wlen, "cluster", 7);
   assign hits.is_create       = word_is(letters, wlen, "create", 6);
   assign hits.is_database     = word_is(letters, wlen, "database", 8);
   assign hits.is_tablespace   = word_is(letters, wlen, "tablespace", 10);
   assign hits.is_unique       = word_is(letters, wlen, "unique", 6);
   assign hits.is_index        = word_is(letters, wlen, "index", 5);
   assign hits.is_concurrently = word_is(letters, wlen, "concurrently", 12);
   assign hits.is_drop         = word_is(letters, wlen, "drop", 4);
   assign hits.is_reindex      = word_is(letters, wlen, "reindex", 7);
   assign hits.is_system       = word_is(letters, wlen, "system", 6);

endmodule

// File: src/snbc_step.sv
module snbc_step import snbc_pkg::*; #(
   parameter int MAX_COMMENT_DEPTH = DEF_MAX_COMMENT_DEPTH,
   localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1)
) (
   input  parse_type          cur,
   input  logic [DEPTH_W-1:0] depth,
   input  word_type           letters,
   input  logic [CODE_W-1:0]  char_code,
   output parse_type          parse_in,
   output logic [DEPTH_W-1:0] depth_in,
   output word_type           letters_in,
   output logic [1:0]         res_class
);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_COMMENT_DEPTH);

   typedef struct packed {
      logic       decide;
      logic [1:0] cls;
      ctx_type    ctx;
   } word_end_type;

   function automatic word_end_type end_word(input ctx_type ctx, input hits_type h);
      word_end_type e;
      e = '{decide: 1'b1, cls: CLASS_ORDINARY, ctx: CX_FIRST};
      case (ctx)
         CX_FIRST: begin
            if (h.is_abort || h.is_begin || h.is_start || h.is_commit || h.is_end ||
                h.is_rollback) begin
               e.cls = CLASS_TXN_CONTROL;
            end else if (h.is_prepare) begin
               e.decide = 1'b0;
               e.ctx    = CX_PREP;
            end else if (h.is_vacuum) begin
               e.cls = CLASS_NO_TXN;
            end else if (h.is_cluster) begin
               e.decide = 1'b0;
               e.ctx    = CX_CLUS;
            end else if (h.is_create) begin
               e.decide = 1'b0;
               e.ctx    = CX_CREATE;
            end else if (h.is_drop || h.is_reindex) begin
               e.decide = 1'b0;
               e.ctx    = CX_DROP;
            end
         end
         CX_PREP: begin
            if (h.is_transaction) e.cls = CLASS_TXN_CONTROL;
         end
         CX_CREATE: begin
            if (h.is_database || h.is_tablespace) begin
               e.cls = CLASS_NO_TXN;
            end else if (h.is_unique) begin
               e.decide = 1'b0;
               e.ctx    = CX_UNIQUE;
            end else if (h.is_index) begin
               e.decide = 1'b0;
               e.ctx    = CX_INDEX;
            end
         end
         CX_UNIQUE: begin
            if (h.is_index) begin
               e.decide = 1'b0;
               e.ctx    = CX_INDEX;
            end
         end
         CX_INDEX: begin
            if (h.is_concurrently) e.cls = CLASS_NO_TXN;
         end
         CX_DROP: begin
            if (h.is_database || h.is_system || h.is_tablespace) e.cls = CLASS_NO_TXN;
         end
         default: begin
            e.cls = CLASS_ORDINARY;
         end
      endcase
      return e;
   endfunction

   // class reached when the text ends in state p
   function automatic logic [1:0] finish_class(input parse_type p, input hits_type h);
      word_end_type e;
      logic [1:0]   cls;
      e   = end_word(p.ctx, h);
      cls = (p.ctx == CX_CLUS) ? CLASS_NO_TXN : CLASS_ORDINARY;
      if (p.in_word) begin
         if (e.decide) cls = e.cls;
         else cls = (e.ctx == CX_CLUS) ? CLASS_NO_TXN : CLASS_ORDINARY;
      end
      return cls;
   endfunction

   logic [CODE_W-1:0]   code;
   logic                is_letter;
   logic                is_space;
   logic [LETTER_W-1:0] letter;
   hits_type            hits_cur;
   hits_type            hits_nxt;
   word_end_type        eword;
   logic                to_skip;
   logic                go;
   ctx_type             sk_ctx;
   logic                sk_line;
   held_type            sk_held;
   logic [DEPTH_W-1:0]  sk_depth;

   assign code      = char_code & CHAR_MASK;
   assign is_letter = (code >= 16'h0061 && code <= 16'h007A) ||
                      (code >= 16'h0041 && code <= 16'h005A);
   assign is_space  = (code >= CH_TAB && code <= CH_CR) || code == CH_SPACE;
   assign letter    = LETTER_W'((code[7:0] | 8'h20) - 8'h61);

   snbc_match u_match_cur (
      .letters (letters),
      .wlen    (cur.wlen),
      .hits    (hits_cur)
   );

   snbc_match u_match_nxt (
      .letters (letters_in),
      .wlen    (parse_in.wlen),
      .hits    (hits_nxt)
   );

   always_comb begin
      parse_in   = cur;
      depth_in   = depth;
      letters_in = letters;
      eword      = end_word(cur.ctx, hits_cur);
      to_skip    = 1'b0;
      go         = 1'b0;
      sk_ctx     = cur.ctx;
      sk_line    = cur.in_line;
      sk_held    = cur.held;
      sk_depth   = depth;

      if (!cur.done) begin
         if (code == '0) begin
            parse_in.done = 1'b1;
            parse_in.cls  = finish_class(cur, hits_cur);
         end else if (cur.in_word) begin
            if (is_letter) begin
               if (cur.wlen < LEN_W'(WORD_CAP)) letters_in[cur.wlen] = letter;
               if (cur.wlen != '1) parse_in.wlen = cur.wlen + 1'b1;
            end else if (eword.decide) begin
               parse_in.done = 1'b1;
               parse_in.cls  = eword.cls;
            end else begin
               // next keyword expected: start a fresh skip
               parse_in.in_word = 1'b0;
               to_skip  = 1'b1;
               sk_ctx   = eword.ctx;
               sk_line  = 1'b0;
               sk_held  = HELD_NONE;
               sk_depth = '0;
            end
         end else begin
            to_skip = 1'b1;
         end
      end

      if (to_skip) begin
         parse_in.ctx     = sk_ctx;
         parse_in.in_line = sk_line;
         parse_in.held    = sk_held;
         depth_in         = sk_depth;
         go               = 1'b1;
         if (sk_line) begin
            go = 1'b0;
            if (code == CH_LF) parse_in.in_line = 1'b0;
         end else if (sk_held != HELD_NONE) begin
            parse_in.held = HELD_NONE;
            if (sk_held == HELD_SLASH && code == CH_STAR) begin
               go = 1'b0;
               if (sk_depth != DEPTH_MAX) depth_in = sk_depth + 1'b1;
            end else if (sk_held == HELD_STAR && code == CH_SLASH && sk_depth != '0) begin
               go       = 1'b0;
               depth_in = sk_depth - 1'b1;
            end else if (sk_held == HELD_DASH && code == CH_DASH && sk_depth == '0) begin
               go               = 1'b0;
               parse_in.in_line = 1'b1;
            end else if (sk_depth == '0) begin
               // held mark was a token of its own
               go            = 1'b0;
               parse_in.done = 1'b1;
               parse_in.cls  = (sk_ctx == CX_CLUS) ? CLASS_NO_TXN : CLASS_ORDINARY;
            end
         end

         if (go && !is_space) begin
            if (code == CH_SLASH) begin
               parse_in.held = HELD_SLASH;
            end else if (code == CH_STAR && sk_depth != '0) begin
               parse_in.held = HELD_STAR;
            end else if (code == CH_DASH && sk_depth == '0) begin
               parse_in.held = HELD_DASH;
            end else if (sk_depth == '0) begin
               if (sk_ctx == CX_CLUS) begin
                  parse_in.done = 1'b1;
                  parse_in.cls  = is_letter ? CLASS_ORDINARY : CLASS_NO_TXN;
               end else if (is_letter) begin
                  parse_in.in_word = 1'b1;
                  parse_in.wlen    = LEN_W'(1);
                  letters_in[0]    = letter;
               end else begin
                  parse_in.done = 1'b1;
                  parse_in.cls  = CLASS_ORDINARY;
               end
            end
         end
      end
   end

   assign res_class = parse_in.done ? parse_in.cls : finish_class(parse_in, hits_nxt);

endmodule

// File: src/sql_no_begin_classifier.sv
// Classifies one SQL statement per frame: the statement streams in one 16-bit code
// unit per request (req_tlast on its final unit), white space and nested or line
// comments are skipped, and leading keywords are matched case-insensitively. When
// the unit marked last is taken, one response gives no_begin and class_code
// (0 ordinary, 1 transaction control, 2 not allowed inside a transaction); state
// then clears for the next statement. A zero code ends the text early. The block
// takes one request every cycle unless a last unit waits on a stalled response; the
// parse state register and its combinational update logic set that rate. A response
// is registered in the input register, then the result register, after its last
// request is accepted; only a stalled response holds back a following last unit.
module sql_no_begin_classifier import snbc_pkg::*; #(
   parameter int MAX_COMMENT_DEPTH = DEF_MAX_COMMENT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [CODE_W-1:0]  req_tdata,   // [15:0] char_code
   input  logic               req_tlast,   // last_char
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata    // [0] no_begin, [2:1] class_code, [7:3] zero
);

   localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

   logic               in_valid_ff, in_valid_in;
   logic [CODE_W-1:0]  in_char_ff;
   logic               in_last_ff;
   parse_type          parse_ff, parse_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   word_type           letters_ff, letters_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_class_ff;
   logic [1:0]         res_class;
   logic               advance;

   assign advance     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   snbc_step #(
      .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
   ) u_step (
      .cur        (parse_ff),
      .depth      (depth_ff),
      .letters    (letters_ff),
      .char_code  (in_char_ff),
      .parse_in   (parse_in),
      .depth_in   (depth_in),
      .letters_in (letters_in),
      .res_class  (res_class)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parse_ff     <= PARSE_RESET;
         depth_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            // clear for the next statement after its last unit
            if (in_last_ff) begin
               parse_ff <= PARSE_RESET;
               depth_ff <= '0;
            end else begin
               parse_ff <= parse_in;
               depth_ff <= depth_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) letters_ff <= letters_in;
      if (advance && in_last_ff) rsp_class_ff <= res_class;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_class_ff, (rsp_class_ff != CLASS_ORDINARY)};

endmodule

// File: sim/tb.sv
module tb;
   import snbc_pkg::*;

   localparam int DIR_ROWS        = 28;
   localparam int RAND_PER_PHASE  = 170;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
      logic              has_fixed;
      logic [1:0]        fixed_cls;
   } unit_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [CODE_W-1:0] req_tdata;   // [15:0] char_code
   logic              req_tlast;   // last_char
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;   // [0] no_begin, [2:1] class_code, [7:3] zero

   sql_no_begin_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Directed statements. In the text, # is a zero code, @ is 16'hFFFF and
   // % is 16'h0141 (ASCII 'A' in the low byte only). -1: use the predictor.
   string dir_text [DIR_ROWS] = '{
      "begin", "ABORT", "StArT transaction", "commit;", "End", "rollback work",
      "prepare transaction 'p1'", "prepare foo", "VACUUM", "cluster",
      "cluster /* ix */ -- note\n", "cluster tbl", "create database d",
      "Create TableSpace t", "create unique index concurrently ix",
      "create  index\tconcurrently", "drop system", "reindex database db",
      " /* a /* b */ c */ -- x\n\tvacuum", "/* open vacuum", "-x", "*/ begin",
      "begin#vacuum", "#", "@", "%begin", "transactionsxyzw", "begin@"
   };
   int dir_class [DIR_ROWS] = '{
      1, 1, -1, -1, -1, -1, -1, -1, 2, -1,
      -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
      -1, -1, -1, 0, 0, -1, -1, -1
   };

   // ---------------- classifier state ----------------
   bit                  cls_done;
   ctx_type             cls_ctx;
   bit                  cls_in_word;
   int                  cmt_depth;
   bit                  in_line;
   logic [CODE_W-1:0]   held_code;
   bit                  held_on;
   logic [LETTER_W-1:0] letters [WORD_CAP];
   int                  word_len;
   logic [1:0]          cls_value;

   function automatic void reset_parse();
      cls_done    = 1'b0;
      cls_ctx     = CX_FIRST;
      cls_in_word = 1'b0;
      cmt_depth   = 0;
      in_line     = 1'b0;
      held_code   = '0;
      held_on     = 1'b0;
      for (int i = 0; i < WORD_CAP; i++) letters[i] = '0;
      word_len    = 0;
      cls_value   = CLASS_ORDINARY;
   endfunction

   function automatic int letter_of(logic [CODE_W-1:0] c);
      if (c >= 16'h0061 && c <= 16'h007A) return int'(c - 16'h0061);
      if (c >= 16'h0041 && c <= 16'h005A) return int'(c - 16'h0041);
      return -1;
   endfunction

   function automatic bit is_blank(logic [CODE_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == 16'h000B ||
             c == 16'h000C || c == CH_CR;
   endfunction

   function automatic bit is_kw(string kw);
      if (word_len != kw.len()) return 1'b0;
      for (int i = 0; i < kw.len(); i++)
         if (letters[i] != LETTER_W'(kw[i] - 8'h61)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void settle(logic [1:0] cls);
      cls_done  = 1'b1;
      cls_value = cls;
   endfunction

   function automatic void skip_into(ctx_type ctx);
      cls_ctx     = ctx;
      cls_in_word = 1'b0;
      cmt_depth   = 0;
      in_line     = 1'b0;
      held_on     = 1'b0;
      held_code   = '0;
   endfunction

   // The current word, possibly empty, has ended.
   function automatic void close_word(ctx_type ctx);
      case (ctx)
         CX_FIRST: begin
            if (is_kw("abort") || is_kw("begin") || is_kw("start") || is_kw("commit") ||
                is_kw("end") || is_kw("rollback")) settle(CLASS_TXN_CONTROL);
            else if (is_kw("prepare")) skip_into(CX_PREP);
            else if (is_kw("vacuum")) settle(CLASS_NO_TXN);
            else if (is_kw("cluster")) skip_into(CX_CLUS);
            else if (is_kw("create")) skip_into(CX_CREATE);
            else if (is_kw("drop") || is_kw("reindex")) skip_into(CX_DROP);
            else settle(CLASS_ORDINARY);
         end
         CX_PREP: settle(is_kw("transaction") ? CLASS_TXN_CONTROL : CLASS_ORDINARY);
         CX_CREATE: begin
            if (is_kw("database") || is_kw("tablespace")) settle(CLASS_NO_TXN);
            else if (is_kw("unique")) skip_into(CX_UNIQUE);
            else if (is_kw("index")) skip_into(CX_INDEX);
            else settle(CLASS_ORDINARY);
         end
         CX_UNIQUE: begin
            if (is_kw("index")) skip_into(CX_INDEX);
            else settle(CLASS_ORDINARY);
         end
         CX_INDEX: settle(is_kw("concurrently") ? CLASS_NO_TXN : CLASS_ORDINARY);
         CX_DROP: settle((is_kw("database") || is_kw("system") || is_kw("tablespace")) ?
                         CLASS_NO_TXN : CLASS_ORDINARY);
         default: settle(CLASS_ORDINARY);
      endcase
   endfunction

   function automatic void keep_letter(int li);
      if (word_len < WORD_CAP) letters[word_len] = LETTER_W'(li);
      if (word_len < 15) word_len++;
   endfunction

   function automatic void open_token(logic [CODE_W-1:0] c);
      int li;
      li = letter_of(c);
      if (cls_ctx == CX_CLUS) begin
         settle(li >= 0 ? CLASS_ORDINARY : CLASS_NO_TXN);
         return;
      end
      word_len = 0;
      if (li >= 0) begin
         cls_in_word = 1'b1;
         keep_letter(li);
      end else begin
         close_word(cls_ctx);
      end
   endfunction

   function automatic void skip_lone(logic [CODE_W-1:0] c);
      if (cmt_depth > 0) return;
      open_token(c);
   endfunction

   function automatic void skip_unit(logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] h;
      if (in_line) begin
         if (c == CH_LF) in_line = 1'b0;
         return;
      end
      if (held_on) begin
         h = held_code;
         held_on = 1'b0;
         held_code = '0;
         if (h == CH_SLASH && c == CH_STAR) begin
            if (cmt_depth < DEF_MAX_COMMENT_DEPTH) cmt_depth++;
            return;
         end
         if (h == CH_STAR && c == CH_SLASH && cmt_depth > 0) begin
            cmt_depth--;
            return;
         end
         if (h == CH_DASH && c == CH_DASH && cmt_depth == 0) begin
            in_line = 1'b1;
            return;
         end
         skip_lone(h);
         if (cls_done || cls_in_word) return;
      end
      if (is_blank(c)) return;
      // hold a possible first half of a comment mark
      if (c == CH_SLASH || (c == CH_STAR && cmt_depth > 0) || (c == CH_DASH && cmt_depth == 0)) begin
         held_code = c;
         held_on = 1'b1;
         return;
      end
      skip_lone(c);
   endfunction

   function automatic void take_unit(logic [CODE_W-1:0] c);
      int li;
      if (cls_done) return;
      if (cls_in_word) begin
         li = letter_of(c);
         if (li >= 0) begin
            keep_letter(li);
            return;
         end
         close_word(cls_ctx);
         if (cls_done) return;
      end
      skip_unit(c);
   endfunction

   function automatic void wrap_up();
      logic [CODE_W-1:0] h;
      if (cls_done) return;
      if (cls_in_word) close_word(cls_ctx);
      if (!cls_done && !cls_in_word && held_on) begin
         h = held_code;
         held_on = 1'b0;
         held_code = '0;
         skip_lone(h);
      end
      if (!cls_done) begin
         if (cls_ctx == CX_CLUS) begin
            settle(CLASS_NO_TXN);
         end else begin
            word_len = 0;
            close_word(cls_ctx);
         end
      end
      cls_done = 1'b1;
   endfunction

   function automatic void classify_unit(input logic [CODE_W-1:0] code, input logic last,
                                         output bit got, output logic [1:0] cls);
      logic [CODE_W-1:0] c;
      c   = code & CHAR_MASK;
      got = 1'b0;
      cls = CLASS_ORDINARY;
      if (!cls_done) begin
         if (c == '0) wrap_up();
         else take_unit(c);
      end
      if (last) begin
         wrap_up();
         got = 1'b1;
         cls = cls_value;
         reset_parse();
      end
   endfunction

   // ---------------- statement generation ----------------
   unit_type          unit_q [$];
   logic [CODE_W-1:0] stmt_buf [$];
   string             chain [$];

   task automatic put_code(logic [CODE_W-1:0] c);
      stmt_buf.push_back(c);
   endtask

   task automatic put_text(string s);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         case (ch)
            8'h23:   put_code(16'h0000);
            8'h40:   put_code(16'hFFFF);
            8'h25:   put_code(16'h0141);
            default: put_code({8'h00, ch});
         endcase
      end
   endtask

   task automatic put_word(string w);
      logic [7:0] ch;
      for (int i = 0; i < w.len(); i++) begin
         ch = w[i];
         if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 2) == 0) ch = ch - 8'h20;
         put_code({8'h00, ch});
      end
   endtask

   function automatic logic [CODE_W-1:0] rand_code();
      case ($urandom_range(0, 5))
         0: return CODE_W'($urandom_range(0, 65535));
         1: return CODE_W'($urandom_range(16'h0020, 16'h007E));
         2: return CODE_W'(16'h0041 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 16'h20 : 16'h0));
         3: begin
            case ($urandom_range(0, 4))
               0: return CH_SLASH;
               1: return CH_STAR;
               2: return CH_DASH;
               3: return CH_SPACE;
               default: return CH_LF;
            endcase
         end
         4: return CODE_W'($urandom_range(16'h0080, 16'hFFFF));
         default: return CODE_W'($urandom_range(0, 16'h001F));
      endcase
   endfunction

   task automatic put_noise(int n);
      repeat (n) put_code(rand_code());
   endtask

   task automatic put_comment(int depth);
      put_text("/*");
      put_noise($urandom_range(0, 4));
      if (depth > 1) put_comment(depth - 1);
      put_noise($urandom_range(0, 3));
      // leave an occasional comment open
      if ($urandom_range(0, 19) != 0) put_text("*/");
   endtask

   task automatic put_gap();
      case ($urandom_range(0, 9))
         0, 1, 2: put_code(CH_SPACE);
         3: put_code(CH_TAB);
         4: begin
            put_code(CH_LF);
            put_code(CH_CR);
         end
         5: begin
            put_code(16'h000B);
            put_code(16'h000C);
            put_code(CH_SPACE);
         end
         6: put_comment($urandom_range(1, 3));
         7: begin
            put_text("--");
            repeat ($urandom_range(0, 4)) put_code(CODE_W'($urandom_range(16'h0020, 16'h007E)));
            put_code(CH_LF);
         end
         8: put_text("/**/");
         default: put_text(";");
      endcase
   endtask

   function automatic string pick_keyword();
      case ($urandom_range(0, 21))
         0: return "abort";
         1: return "begin";
         2: return "start";
         3: return "commit";
         4: return "end";
         5: return "rollback";
         6: return "prepare";
         7: return "transaction";
         8: return "vacuum";
         9: return "cluster";
         10: return "create";
         11: return "database";
         12: return "tablespace";
         13: return "unique";
         14: return "index";
         15: return "concurrently";
         16: return "drop";
         17: return "reindex";
         18: return "system";
         19: return "select";
         20: return "table";
         default: return "z";
      endcase
   endfunction

   function automatic string bend_word(string w);
      case ($urandom_range(0, 15))
         0: return (w.len() > 1) ? w.substr(0, w.len() - 2) : "q";
         1: return {w, "s"};
         2: return {w, w};
         3: return {w, "xxxxxxxxxxxx"};
         default: return w;
      endcase
   endfunction

   task automatic pick_chain();
      chain.delete();
      case ($urandom_range(0, 21))
         0: chain.push_back("abort");
         1: chain.push_back("begin");
         2: chain.push_back("start");
         3: chain.push_back("commit");
         4: chain.push_back("end");
         5: chain.push_back("rollback");
         6: begin chain.push_back("prepare"); chain.push_back("transaction"); end
         7: begin chain.push_back("prepare"); chain.push_back(pick_keyword()); end
         8: chain.push_back("vacuum");
         9: chain.push_back("cluster");
         10: begin chain.push_back("cluster"); chain.push_back(pick_keyword()); end
         11: begin chain.push_back("create"); chain.push_back("database"); end
         12: begin chain.push_back("create"); chain.push_back("tablespace"); end
         13: begin
            chain.push_back("create");
            chain.push_back("unique");
            chain.push_back("index");
            chain.push_back("concurrently");
         end
         14: begin
            chain.push_back("create");
            chain.push_back("index");
            chain.push_back("concurrently");
         end
         15: begin
            chain.push_back("create");
            chain.push_back("unique");
            chain.push_back(pick_keyword());
         end
         16: begin
            chain.push_back("create");
            chain.push_back("index");
            chain.push_back(pick_keyword());
         end
         17, 18: begin
            if ($urandom_range(0, 1)) chain.push_back("drop");
            else chain.push_back("reindex");
            case ($urandom_range(0, 2))
               0: chain.push_back("database");
               1: chain.push_back("system");
               default: chain.push_back("tablespace");
            endcase
         end
         19: begin
            if ($urandom_range(0, 1)) chain.push_back("drop");
            else chain.push_back("reindex");
            chain.push_back(pick_keyword());
         end
         20: begin chain.push_back("create"); chain.push_back(pick_keyword()); end
         default: chain.push_back(pick_keyword());
      endcase
   endtask

   task automatic close_stmt(int fixed);
      unit_type u;
      if (stmt_buf.size() == 0) stmt_buf.push_back(CH_SPACE);
      for (int i = 0; i < stmt_buf.size(); i++) begin
         u.code      = stmt_buf[i];
         u.last      = (i == stmt_buf.size() - 1);
         u.has_fixed = (fixed >= 0);
         u.fixed_cls = fixed[1:0];
         unit_q.push_back(u);
      end
      stmt_buf.delete();
   endtask

   task automatic build_random_stmt();
      if ($urandom_range(0, 99) < 15) begin
         put_noise($urandom_range(1, 12));
      end else begin
         pick_chain();
         if ($urandom_range(0, 3) == 0) put_gap();
         for (int i = 0; i < chain.size(); i++) begin
            if (i > 0) put_gap();
            put_word(bend_word(chain[i]));
         end
         case ($urandom_range(0, 7))
            0, 1: ;
            2: put_gap();
            3: begin put_gap(); put_word(pick_keyword()); end
            4: begin put_gap(); put_text("t1;"); end
            5: begin put_code(16'h0000); put_noise($urandom_range(0, 3)); end
            6: put_noise($urandom_range(1, 3));
            default: begin put_gap(); put_comment(1); end
         endcase
      end
      close_stmt(-1);
   endtask

   // ---------------- driving ----------------
   int       send_idle_pct = 0;
   int       stall_pct     = 0;
   unit_type on_bus;

   task automatic drive_units();
      unit_type u;
      while (unit_q.size() > 0) begin
         u = unit_q.pop_front();
         if ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
         end
         on_bus = u;
         req_tvalid <= 1'b1;
         req_tdata  <= u.code;
         req_tlast  <= u.last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   // ---------------- checking ----------------
   logic [1:0] class_q [$];
   bit         mon_got;
   logic [1:0] mon_cls;
   logic [1:0] want_cls;
   int         units_taken    = 0;
   int         results_seen   = 0;
   int         mismatch_count = 0;
   int         idle_cycles    = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            units_taken++;
            classify_unit(req_tdata, req_tlast, mon_got, mon_cls);
            if (mon_got) class_q.push_back(on_bus.has_fixed ? on_bus.fixed_cls : mon_cls);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (class_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got no_begin %0d class %0d",
                        $time, rsp_tdata[0], rsp_tdata[2:1]);
               mismatch_count++;
            end else begin
               want_cls = class_q.pop_front();
               if (rsp_tdata[0] !== (want_cls != CLASS_ORDINARY)) begin
                  $display("%0t: no_begin expected %0d got %0d", $time,
                           want_cls != CLASS_ORDINARY, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2:1] !== want_cls) begin
                  $display("%0t: class_code expected %0d got %0d", $time, want_cls,
                           rsp_tdata[2:1]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:3] !== 5'd0) begin
                  $display("%0t: pad bits expected 0 got %0h", $time, rsp_tdata[7:3]);
                  mismatch_count++;
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int base;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      reset_parse();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         if (ph == 0) begin
            for (int r = 0; r < DIR_ROWS; r++) begin
               put_text(dir_text[r]);
               close_stmt(dir_class[r]);
            end
         end
         base = unit_q.size();
         while (unit_q.size() < base + RAND_PER_PHASE) build_random_stmt();
         drive_units();
         while (class_q.size() != 0) @(posedge clock);
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d code units in %0d statements: directed table, then random text",
               units_taken, results_seen);
      $display("tb: paced as free flow, sender gaps, receiver stalls, then both");
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
